>>> hdl/soa_pkg.sv
// Shared types, constants and sequencer states of the slab object allocator.
package soa_pkg;

  localparam int NUM_SLABS  = 64;
  localparam int SLAB_W     = $clog2(NUM_SLABS);
  localparam int MAX_SLOTS  = 64;
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int MARK_W     = 7;
  localparam int GROW_BATCH = 4;
  localparam int BATCH_W    = $clog2(GROW_BATCH + 1);
  localparam int TIMER_W    = 16;
  localparam int OBJS_W     = 7;
  localparam int LINK_AW    = SLAB_W + SLOT_W;

  localparam logic [MARK_W-1:0] NONE_MARK  = MARK_W'(NUM_SLABS);
  localparam logic [MARK_W-1:0] EMPTY_MARK = MARK_W'(MAX_SLOTS);

  localparam logic [1:0] OP_ALLOC      = 2'd0;
  localparam logic [1:0] OP_FREE       = 2'd1;
  localparam logic [1:0] OP_MAINT      = 2'd2;
  localparam logic [1:0] OP_MAINT_ZERO = 2'd3;

  localparam logic CFG_OBJS     = 1'b0;
  localparam logic CFG_INTERVAL = 1'b1;

  typedef enum logic [1:0] {
    TAG_POOL,
    TAG_PARTIAL,
    TAG_FULL,
    TAG_SPARE
  } soa_tag_t;

  typedef struct packed {
    logic [MARK_W-1:0] top;
    logic [MARK_W-1:0] used;
    logic [MARK_W-1:0] nxt;
    logic [MARK_W-1:0] prv;
    soa_tag_t          tag;
  } soa_rec_t;

  localparam soa_rec_t REC_RESET = '{
    top: EMPTY_MARK, used: '0, nxt: NONE_MARK, prv: NONE_MARK, tag: TAG_POOL};

  typedef struct packed {
    logic              rd_en;
    logic [SLAB_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLAB_W-1:0] wr_addr;
    soa_rec_t          wr_data;
  } soa_rec_req_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_LOAD, ST_LOAD_W, ST_STORE, ST_NB, ST_NB_W,
    ST_MV_START, ST_MV_RM2, ST_MV_RM3, ST_MV_PUSH, ST_MV_PUSH2,
    ST_A_SPARE, ST_A_SP2, ST_A_SP3, ST_A_POP, ST_A_POPW, ST_A_POPCHK,
    ST_A_WB, ST_A_TMR,
    ST_G_RD, ST_G_CHK, ST_G_INIT, ST_G_PUSH, ST_G_WB, ST_G_END,
    ST_F_CHK, ST_R_START, ST_R_LINK,
    ST_M_START, ST_M_HCHK, ST_M_REL, ST_M_REL2, ST_M_REL3, ST_M_TMR,
    ST_DONE
  } soa_state_t;

endpackage

>>> hdl/soa_rec_mem.sv
// Slab record memory with per-entry valid bits; unwritten entries read as the reset record.
module soa_rec_mem (
  input  logic                  clk,
  input  logic                  rst,
  input  soa_pkg::soa_rec_req_t req,
  output soa_pkg::soa_rec_t     rd_data
);

  soa_pkg::soa_rec_t                 mem [soa_pkg::NUM_SLABS];
  logic [soa_pkg::NUM_SLABS-1:0]     vld;
  soa_pkg::soa_rec_t                 rd_q;
  logic                              rd_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (req.rd_en) begin
      rd_vld <= vld[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_q : soa_pkg::REC_RESET;

endmodule

>>> hdl/slab_object_allocator.sv
// One request at a time: in_stall is high while the sequencer over the slab record and slot
// link memories is busy, and the next request is taken only once the result has been loaded
// into the output register. Each list relink reads a neighbour's slab record and writes it back.
// A grow reads each slab record in turn, then writes one slot link per cycle per new slab;
// maintenance releases spare slabs one at a time. Reset: all slabs in the pool, no clearing.
module slab_object_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic [5:0]                    slab_index,
  input  logic [5:0]                    slot_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          granted,
  output logic [5:0]                    out_slab,
  output logic [5:0]                    out_slot,
  output logic                          reclaimed,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data
);

  localparam int MW = soa_pkg::MARK_W;
  localparam int SW = soa_pkg::SLAB_W;
  localparam int LW = soa_pkg::SLOT_W;

  soa_pkg::soa_state_t state, state_next, ret, ret_next, mv_ret, mv_ret_next;
  soa_pkg::soa_state_t r_ret, r_ret_next;
  soa_pkg::soa_tag_t   mv_from, mv_from_next, mv_to, mv_to_next;
  soa_pkg::soa_rec_t   r, r_next, rdata, nb_mod;
  soa_pkg::soa_rec_req_t rreq;

  logic [SW-1:0] cur_s, cur_s_next, nb_addr, nb_addr_next;
  logic          nb_prv, nb_prv_next;
  logic [MW-1:0] nb_val, nb_val_next;
  logic [LW-1:0] rslot, rslot_next;
  logic [MW-1:0] scan, scan_next, k, k_next;
  logic [soa_pkg::BATCH_W-1:0] taken, taken_next;
  logic          a_spare, a_spare_next;
  logic [MW-1:0] mlim, mlim_next;
  logic [MW-1:0] ph, ph_next, fh, fh_next, sh, sh_next;
  logic [MW-1:0] busy_cnt, busy_cnt_next, owned, owned_next, peak, peak_next;
  logic [MW-1:0] adaptive, adaptive_next;
  logic [soa_pkg::TIMER_W-1:0] timer, timer_next, interval_len;
  logic          held_valid, held_valid_next;
  logic [SW-1:0] held_slab, held_slab_next;
  logic [LW-1:0] held_slot, held_slot_next;
  logic          res_granted, res_granted_next, res_rec, res_rec_next;
  logic [SW-1:0] res_slab, res_slab_next;
  logic [LW-1:0] res_slot, res_slot_next;
  logic [soa_pkg::OBJS_W-1:0] objects_per_slab, eff;
  logic [MW-1:0] h;
  logic          in_use, out_load;

  logic [MW-1:0]                link_mem [2**soa_pkg::LINK_AW];
  logic [MW-1:0]                link_q;
  logic                         lw_en, lr_en;
  logic [soa_pkg::LINK_AW-1:0]  lw_addr, lr_addr;
  logic [MW-1:0]                lw_data;

  soa_rec_mem u_rec (
    .clk     (clk),
    .rst     (rst),
    .req     (rreq),
    .rd_data (rdata)
  );

  always_comb begin
    if (objects_per_slab < soa_pkg::OBJS_W'(2)) begin
      eff = soa_pkg::OBJS_W'(2);
    end else if (objects_per_slab > soa_pkg::OBJS_W'(soa_pkg::MAX_SLOTS)) begin
      eff = soa_pkg::OBJS_W'(soa_pkg::MAX_SLOTS);
    end else begin
      eff = objects_per_slab;
    end
  end

  assign in_use = (r.tag == soa_pkg::TAG_PARTIAL) || (r.tag == soa_pkg::TAG_FULL);

  always_comb begin
    case (mv_to)
      soa_pkg::TAG_PARTIAL: h = ph;
      soa_pkg::TAG_FULL:    h = fh;
      default:              h = sh;
    endcase
  end

  // next state
  always_comb begin
    state_next       = state;
    ret_next         = ret;
    mv_ret_next      = mv_ret;
    r_ret_next       = r_ret;
    mv_from_next     = mv_from;
    mv_to_next       = mv_to;
    r_next           = r;
    cur_s_next       = cur_s;
    nb_addr_next     = nb_addr;
    nb_prv_next      = nb_prv;
    nb_val_next      = nb_val;
    rslot_next       = rslot;
    scan_next        = scan;
    k_next           = k;
    taken_next       = taken;
    a_spare_next     = a_spare;
    mlim_next        = mlim;
    ph_next          = ph;
    fh_next          = fh;
    sh_next          = sh;
    busy_cnt_next    = busy_cnt;
    owned_next       = owned;
    peak_next        = peak;
    adaptive_next    = adaptive;
    timer_next       = timer;
    held_valid_next  = held_valid;
    held_slab_next   = held_slab;
    held_slot_next   = held_slot;
    res_granted_next = res_granted;
    res_rec_next     = res_rec;
    res_slab_next    = res_slab;
    res_slot_next    = res_slot;
    case (state)
      soa_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_granted_next = 1'b0;
          res_rec_next     = 1'b0;
          res_slab_next    = '0;
          res_slot_next    = '0;
          case (op)
            soa_pkg::OP_ALLOC: begin
              timer_next   = timer - soa_pkg::TIMER_W'(1);
              a_spare_next = 1'b0;
              if (ph < soa_pkg::NONE_MARK) begin
                cur_s_next = ph[SW-1:0];
                ret_next   = soa_pkg::ST_A_POP;
                state_next = soa_pkg::ST_LOAD;
              end else if (sh < soa_pkg::NONE_MARK) begin
                state_next = soa_pkg::ST_A_SPARE;
              end else begin
                scan_next  = '0;
                taken_next = '0;
                state_next = soa_pkg::ST_G_RD;
              end
            end
            soa_pkg::OP_FREE: begin
              cur_s_next = slab_index;
              rslot_next = slot_index;
              ret_next   = soa_pkg::ST_F_CHK;
              state_next = soa_pkg::ST_LOAD;
            end
            soa_pkg::OP_MAINT: begin
              mlim_next  = adaptive;
              state_next = soa_pkg::ST_M_START;
            end
            default: begin
              mlim_next  = '0;
              state_next = soa_pkg::ST_M_START;
            end
          endcase
        end
      end
      soa_pkg::ST_LOAD:   state_next = soa_pkg::ST_LOAD_W;
      soa_pkg::ST_LOAD_W: begin
        r_next     = rdata;
        state_next = ret;
      end
      soa_pkg::ST_STORE:  state_next = ret;
      soa_pkg::ST_NB:     state_next = soa_pkg::ST_NB_W;
      soa_pkg::ST_NB_W:   state_next = ret;
      soa_pkg::ST_MV_START: begin
        if (mv_from == soa_pkg::TAG_POOL) begin
          state_next = soa_pkg::ST_MV_PUSH;
        end else if (r.nxt < soa_pkg::NONE_MARK) begin
          nb_addr_next = r.nxt[SW-1:0];
          nb_prv_next  = 1'b1;
          nb_val_next  = r.prv;
          ret_next     = soa_pkg::ST_MV_RM2;
          state_next   = soa_pkg::ST_NB;
        end else begin
          state_next = soa_pkg::ST_MV_RM2;
        end
      end
      soa_pkg::ST_MV_RM2: begin
        if (r.prv < soa_pkg::NONE_MARK) begin
          nb_addr_next = r.prv[SW-1:0];
          nb_prv_next  = 1'b0;
          nb_val_next  = r.nxt;
          ret_next     = soa_pkg::ST_MV_RM3;
          state_next   = soa_pkg::ST_NB;
        end else begin
          state_next = soa_pkg::ST_MV_RM3;
        end
      end
      soa_pkg::ST_MV_RM3: begin
        case (mv_from)
          soa_pkg::TAG_PARTIAL: if (ph == MW'(cur_s)) ph_next = r.nxt;
          soa_pkg::TAG_FULL:    if (fh == MW'(cur_s)) fh_next = r.nxt;
          default:              if (sh == MW'(cur_s)) sh_next = r.nxt;
        endcase
        r_next.nxt = soa_pkg::NONE_MARK;
        r_next.prv = soa_pkg::NONE_MARK;
        r_next.tag = soa_pkg::TAG_POOL;
        state_next = soa_pkg::ST_MV_PUSH;
      end
      soa_pkg::ST_MV_PUSH: begin
        if (mv_to == soa_pkg::TAG_POOL) begin
          state_next = mv_ret;
        end else if (h < soa_pkg::NONE_MARK) begin
          nb_addr_next = h[SW-1:0];
          nb_prv_next  = 1'b1;
          nb_val_next  = MW'(cur_s);
          ret_next     = soa_pkg::ST_MV_PUSH2;
          state_next   = soa_pkg::ST_NB;
        end else begin
          state_next = soa_pkg::ST_MV_PUSH2;
        end
      end
      soa_pkg::ST_MV_PUSH2: begin
        r_next.nxt = h;
        r_next.prv = soa_pkg::NONE_MARK;
        r_next.tag = mv_to;
        case (mv_to)
          soa_pkg::TAG_PARTIAL: ph_next = MW'(cur_s);
          soa_pkg::TAG_FULL:    fh_next = MW'(cur_s);
          default:              sh_next = MW'(cur_s);
        endcase
        state_next = mv_ret;
      end
      soa_pkg::ST_A_SPARE: begin
        cur_s_next = sh[SW-1:0];
        ret_next   = soa_pkg::ST_A_SP2;
        state_next = soa_pkg::ST_LOAD;
      end
      soa_pkg::ST_A_SP2: begin
        mv_from_next = soa_pkg::TAG_SPARE;
        mv_to_next   = soa_pkg::TAG_PARTIAL;
        mv_ret_next  = soa_pkg::ST_A_SP3;
        state_next   = soa_pkg::ST_MV_START;
      end
      soa_pkg::ST_A_SP3: begin
        busy_cnt_next = busy_cnt + MW'(1);
        if (busy_cnt + MW'(1) > peak) peak_next = busy_cnt + MW'(1);
        a_spare_next = 1'b1;
        state_next   = soa_pkg::ST_A_POP;
      end
      soa_pkg::ST_A_POP: begin
        if (r.top < soa_pkg::EMPTY_MARK) begin
          res_slot_next = r.top[LW-1:0];
          state_next    = soa_pkg::ST_A_POPW;
        end else begin
          res_slot_next = '0;
          state_next    = soa_pkg::ST_A_POPCHK;
        end
      end
      soa_pkg::ST_A_POPW: begin
        r_next.top  = link_q;
        r_next.used = r.used + MW'(1);
        state_next  = soa_pkg::ST_A_POPCHK;
      end
      soa_pkg::ST_A_POPCHK: begin
        res_granted_next = 1'b1;
        res_slab_next    = cur_s;
        if (!a_spare && r.top >= soa_pkg::EMPTY_MARK) begin
          mv_from_next = soa_pkg::TAG_PARTIAL;
          mv_to_next   = soa_pkg::TAG_FULL;
          mv_ret_next  = soa_pkg::ST_A_WB;
          state_next   = soa_pkg::ST_MV_START;
        end else begin
          state_next = soa_pkg::ST_A_WB;
        end
      end
      soa_pkg::ST_A_WB: begin
        ret_next   = soa_pkg::ST_A_TMR;
        state_next = soa_pkg::ST_STORE;
      end
      soa_pkg::ST_A_TMR: begin
        if (timer == '0) begin
          mlim_next  = adaptive;
          state_next = soa_pkg::ST_M_START;
        end else begin
          state_next = soa_pkg::ST_DONE;
        end
      end
      soa_pkg::ST_G_RD: begin
        if (scan >= MW'(soa_pkg::NUM_SLABS) ||
            taken == soa_pkg::BATCH_W'(soa_pkg::GROW_BATCH)) begin
          state_next = soa_pkg::ST_G_END;
        end else begin
          cur_s_next = scan[SW-1:0];
          ret_next   = soa_pkg::ST_G_CHK;
          state_next = soa_pkg::ST_LOAD;
        end
      end
      soa_pkg::ST_G_CHK: begin
        if (r.tag != soa_pkg::TAG_POOL) begin
          scan_next  = scan + MW'(1);
          state_next = soa_pkg::ST_G_RD;
        end else begin
          k_next     = '0;
          state_next = soa_pkg::ST_G_INIT;
        end
      end
      soa_pkg::ST_G_INIT: begin
        if (k == MW'(eff) - MW'(1)) begin
          state_next = soa_pkg::ST_G_PUSH;
        end else begin
          k_next = k + MW'(1);
        end
      end
      soa_pkg::ST_G_PUSH: begin
        r_next.top   = MW'(eff) - MW'(1);
        r_next.used  = '0;
        mv_from_next = soa_pkg::TAG_POOL;
        mv_to_next   = soa_pkg::TAG_SPARE;
        mv_ret_next  = soa_pkg::ST_G_WB;
        state_next   = soa_pkg::ST_MV_START;
      end
      soa_pkg::ST_G_WB: begin
        owned_next = owned + MW'(1);
        taken_next = taken + soa_pkg::BATCH_W'(1);
        scan_next  = scan + MW'(1);
        ret_next   = soa_pkg::ST_G_RD;
        state_next = soa_pkg::ST_STORE;
      end
      soa_pkg::ST_G_END: begin
        if (sh < soa_pkg::NONE_MARK) begin
          state_next = soa_pkg::ST_A_SPARE;
        end else begin
          state_next = soa_pkg::ST_A_TMR;
        end
      end
      soa_pkg::ST_F_CHK: begin
        state_next = soa_pkg::ST_DONE;
        if (MW'(rslot) < MW'(eff) && in_use) begin
          if (held_valid) begin
            r_ret_next = soa_pkg::ST_DONE;
            state_next = soa_pkg::ST_R_START;
          end else begin
            held_valid_next = 1'b1;
            held_slab_next  = cur_s;
            held_slot_next  = rslot;
          end
        end
      end
      soa_pkg::ST_R_START: begin
        if (r.tag == soa_pkg::TAG_FULL) begin
          mv_from_next = soa_pkg::TAG_FULL;
          mv_to_next   = soa_pkg::TAG_PARTIAL;
          mv_ret_next  = soa_pkg::ST_R_LINK;
          state_next   = soa_pkg::ST_MV_START;
        end else if (r.used == MW'(1)) begin
          busy_cnt_next = busy_cnt - MW'(1);
          mv_from_next  = soa_pkg::TAG_PARTIAL;
          mv_to_next    = soa_pkg::TAG_SPARE;
          mv_ret_next   = soa_pkg::ST_R_LINK;
          state_next    = soa_pkg::ST_MV_START;
        end else begin
          state_next = soa_pkg::ST_R_LINK;
        end
      end
      soa_pkg::ST_R_LINK: begin
        r_next.top  = MW'(rslot);
        r_next.used = r.used - MW'(1);
        ret_next    = r_ret;
        state_next  = soa_pkg::ST_STORE;
      end
      soa_pkg::ST_M_START: begin
        if (held_valid) begin
          held_valid_next = 1'b0;
          res_rec_next    = 1'b1;
          cur_s_next      = held_slab;
          rslot_next      = held_slot;
          ret_next        = soa_pkg::ST_M_HCHK;
          state_next      = soa_pkg::ST_LOAD;
        end else begin
          state_next = soa_pkg::ST_M_REL;
        end
      end
      soa_pkg::ST_M_HCHK: begin
        if (in_use && MW'(rslot) < MW'(eff)) begin
          r_ret_next = soa_pkg::ST_M_REL;
          state_next = soa_pkg::ST_R_START;
        end else begin
          state_next = soa_pkg::ST_M_REL;
        end
      end
      soa_pkg::ST_M_REL: begin
        if (owned > mlim && sh < soa_pkg::NONE_MARK) begin
          cur_s_next = sh[SW-1:0];
          ret_next   = soa_pkg::ST_M_REL2;
          state_next = soa_pkg::ST_LOAD;
        end else begin
          state_next = soa_pkg::ST_M_TMR;
        end
      end
      soa_pkg::ST_M_REL2: begin
        mv_from_next = soa_pkg::TAG_SPARE;
        mv_to_next   = soa_pkg::TAG_POOL;
        mv_ret_next  = soa_pkg::ST_M_REL3;
        state_next   = soa_pkg::ST_MV_START;
      end
      soa_pkg::ST_M_REL3: begin
        owned_next   = owned - MW'(1);
        res_rec_next = 1'b1;
        ret_next     = soa_pkg::ST_M_REL;
        state_next   = soa_pkg::ST_STORE;
      end
      soa_pkg::ST_M_TMR: begin
        if (timer == '0) begin
          adaptive_next = peak;
          peak_next     = busy_cnt;
          timer_next    = interval_len;
        end
        state_next = soa_pkg::ST_DONE;
      end
      soa_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) state_next = soa_pkg::ST_IDLE;
      end
      default: state_next = soa_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rreq.rd_en   = 1'b0;
    rreq.rd_addr = cur_s;
    rreq.wr_en   = 1'b0;
    rreq.wr_addr = cur_s;
    rreq.wr_data = r;
    nb_mod       = rdata;
    lw_en        = 1'b0;
    lw_addr      = {cur_s, rslot};
    lw_data      = r.top;
    lr_en        = 1'b0;
    lr_addr      = {cur_s, r.top[LW-1:0]};
    if (nb_prv) begin
      nb_mod.prv = nb_val;
    end else begin
      nb_mod.nxt = nb_val;
    end
    case (state)
      soa_pkg::ST_LOAD: rreq.rd_en = 1'b1;
      soa_pkg::ST_NB: begin
        rreq.rd_en   = 1'b1;
        rreq.rd_addr = nb_addr;
      end
      soa_pkg::ST_NB_W: begin
        rreq.wr_en   = 1'b1;
        rreq.wr_addr = nb_addr;
        rreq.wr_data = nb_mod;
      end
      soa_pkg::ST_STORE: rreq.wr_en = 1'b1;
      soa_pkg::ST_A_POP: lr_en = (r.top < soa_pkg::EMPTY_MARK);
      soa_pkg::ST_G_INIT: begin
        lw_en   = 1'b1;
        lw_addr = {cur_s, k[LW-1:0]};
        lw_data = (k == '0) ? soa_pkg::EMPTY_MARK : k - MW'(1);
      end
      soa_pkg::ST_R_LINK: lw_en = 1'b1;
      default: ;
    endcase
  end

  assign in_stall = (state != soa_pkg::ST_IDLE);
  assign out_load = (state == soa_pkg::ST_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (lr_en) begin
      link_q <= link_mem[lr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= soa_pkg::ST_IDLE;
      ph               <= soa_pkg::NONE_MARK;
      fh               <= soa_pkg::NONE_MARK;
      sh               <= soa_pkg::NONE_MARK;
      busy_cnt         <= '0;
      owned            <= '0;
      peak             <= '0;
      adaptive         <= MW'(soa_pkg::NUM_SLABS);
      held_valid       <= 1'b0;
      held_slab        <= '0;
      held_slot        <= '0;
      objects_per_slab <= soa_pkg::OBJS_W'(64);
      interval_len     <= soa_pkg::TIMER_W'(1024);
      timer            <= soa_pkg::TIMER_W'(1024);
      out_valid        <= 1'b0;
    end else begin
      state      <= state_next;
      ph         <= ph_next;
      fh         <= fh_next;
      sh         <= sh_next;
      busy_cnt   <= busy_cnt_next;
      owned      <= owned_next;
      peak       <= peak_next;
      adaptive   <= adaptive_next;
      held_valid <= held_valid_next;
      held_slab  <= held_slab_next;
      held_slot  <= held_slot_next;
      timer      <= timer_next;
      if (cfg_we) begin
        case (cfg_index)
          soa_pkg::CFG_OBJS: objects_per_slab <= cfg_data[soa_pkg::OBJS_W-1:0];
          soa_pkg::CFG_INTERVAL: begin
            interval_len <= cfg_data;
            timer        <= cfg_data;
          end
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ret         <= ret_next;
    mv_ret      <= mv_ret_next;
    r_ret       <= r_ret_next;
    mv_from     <= mv_from_next;
    mv_to       <= mv_to_next;
    r           <= r_next;
    cur_s       <= cur_s_next;
    nb_addr     <= nb_addr_next;
    nb_prv      <= nb_prv_next;
    nb_val      <= nb_val_next;
    rslot       <= rslot_next;
    scan        <= scan_next;
    k           <= k_next;
    taken       <= taken_next;
    a_spare     <= a_spare_next;
    mlim        <= mlim_next;
    res_granted <= res_granted_next;
    res_rec     <= res_rec_next;
    res_slab    <= res_slab_next;
    res_slot    <= res_slot_next;
    if (out_load) begin
      granted   <= res_granted;
      out_slab  <= res_slab;
      out_slot  <= res_slot;
      reclaimed <= res_rec;
    end
  end

endmodule

>>> verif/soa_checker.sv
// Request and result monitor with a slab allocator predictor and field-by-field comparison.
`timescale 1ns / 100ps
module soa_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  op,
  input  logic [5:0]  slab_index,
  input  logic [5:0]  slot_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        granted,
  input  logic [5:0]  out_slab,
  input  logic [5:0]  out_slot,
  input  logic        reclaimed,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          grants,
  output int          reclaims
);

  typedef struct packed {
    logic       granted;
    logic [5:0] slab;
    logic [5:0] slot;
    logic       reclaimed;
  } alloc_result_t;

  alloc_result_t awaited[$];

  logic [6:0]  objs_reg;
  logic [15:0] interval_reg;
  logic [6:0]  link[soa_pkg::NUM_SLABS*soa_pkg::MAX_SLOTS];
  logic [6:0]  stack_top[soa_pkg::NUM_SLABS];
  logic [6:0]  slab_fill[soa_pkg::NUM_SLABS];
  logic [6:0]  nxt[soa_pkg::NUM_SLABS];
  logic [6:0]  prv[soa_pkg::NUM_SLABS];
  soa_pkg::soa_tag_t tag[soa_pkg::NUM_SLABS];
  logic [6:0]  partial_hd, full_hd, spare_hd;
  logic [6:0]  used_slabs, owned_slabs, peak_slabs;
  logic [15:0] timer;
  logic [6:0]  slab_limit;
  logic        held_v;
  logic [5:0]  held_sl, held_so;

  function automatic logic [6:0] slots_per_slab();
    if (objs_reg < 7'd2) return 7'd2;
    if (objs_reg > 7'(soa_pkg::MAX_SLOTS)) return 7'(soa_pkg::MAX_SLOTS);
    return objs_reg;
  endfunction

  function automatic logic [6:0] head_get(soa_pkg::soa_tag_t t);
    if (t == soa_pkg::TAG_PARTIAL) return partial_hd;
    if (t == soa_pkg::TAG_FULL) return full_hd;
    return spare_hd;
  endfunction

  function automatic void head_set(soa_pkg::soa_tag_t t, logic [6:0] v);
    if (t == soa_pkg::TAG_PARTIAL) partial_hd = v;
    else if (t == soa_pkg::TAG_FULL) full_hd = v;
    else spare_hd = v;
  endfunction

  function automatic void push_slab(soa_pkg::soa_tag_t t, logic [5:0] s);
    logic [6:0] h;
    h = head_get(t);
    nxt[s] = h;
    prv[s] = soa_pkg::NONE_MARK;
    if (h < soa_pkg::NONE_MARK) prv[h[5:0]] = {1'b0, s};
    head_set(t, {1'b0, s});
    tag[s] = t;
  endfunction

  function automatic void unlink_slab(soa_pkg::soa_tag_t t, logic [5:0] s);
    logic [6:0] n, p;
    n = nxt[s];
    p = prv[s];
    if (n < soa_pkg::NONE_MARK) prv[n[5:0]] = p;
    if (p < soa_pkg::NONE_MARK) nxt[p[5:0]] = n;
    if (head_get(t) == {1'b0, s}) head_set(t, n);
    nxt[s] = soa_pkg::NONE_MARK;
    prv[s] = soa_pkg::NONE_MARK;
    tag[s] = soa_pkg::TAG_POOL;
  endfunction

  function automatic logic [5:0] take_slot(logic [5:0] s);
    logic [6:0] t;
    t = stack_top[s];
    if (t >= 7'(soa_pkg::MAX_SLOTS)) return 6'd0;
    stack_top[s] = link[{s, t[5:0]}];
    slab_fill[s] = slab_fill[s] + 7'd1;
    return t[5:0];
  endfunction

  function automatic void give_back(logic [5:0] s, logic [5:0] so);
    if (tag[s] == soa_pkg::TAG_FULL) begin
      unlink_slab(soa_pkg::TAG_FULL, s);
      push_slab(soa_pkg::TAG_PARTIAL, s);
    end else if (slab_fill[s] == 7'd1) begin
      unlink_slab(soa_pkg::TAG_PARTIAL, s);
      push_slab(soa_pkg::TAG_SPARE, s);
      used_slabs = used_slabs - 7'd1;
    end
    link[{s, so}] = stack_top[s];
    stack_top[s] = {1'b0, so};
    slab_fill[s] = slab_fill[s] - 7'd1;
  endfunction

  function automatic logic in_use(logic [5:0] s);
    return tag[s] == soa_pkg::TAG_PARTIAL || tag[s] == soa_pkg::TAG_FULL;
  endfunction

  function automatic void grow_pool();
    int taken;
    logic [6:0] n;
    taken = 0;
    n = slots_per_slab();
    for (int s = 0; s < soa_pkg::NUM_SLABS && taken < soa_pkg::GROW_BATCH; s++) begin
      if (tag[s] == soa_pkg::TAG_POOL) begin
        for (int k = 0; k < int'(n); k++)
          link[s*soa_pkg::MAX_SLOTS+k] = (k == 0) ? soa_pkg::EMPTY_MARK : 7'(k - 1);
        stack_top[s] = n - 7'd1;
        slab_fill[s] = '0;
        push_slab(soa_pkg::TAG_SPARE, 6'(s));
        owned_slabs = owned_slabs + 7'd1;
        taken++;
      end
    end
  endfunction

  function automatic logic run_maintenance(logic [6:0] lim);
    logic r;
    r = 1'b0;
    if (held_v) begin
      if (in_use(held_sl) && {1'b0, held_so} < slots_per_slab()) give_back(held_sl, held_so);
      held_v = 1'b0;
      r = 1'b1;
    end
    while (owned_slabs > lim && spare_hd < soa_pkg::NONE_MARK) begin
      unlink_slab(soa_pkg::TAG_SPARE, spare_hd[5:0]);
      owned_slabs = owned_slabs - 7'd1;
      r = 1'b1;
    end
    if (timer == 16'd0) begin
      slab_limit = peak_slabs;
      peak_slabs = used_slabs;
      timer = interval_reg;
    end
    return r;
  endfunction

  function automatic alloc_result_t predict_request(logic [1:0] o, logic [5:0] sl,
                                                    logic [5:0] so);
    alloc_result_t r;
    logic [5:0] s;
    r = '0;
    if (o == soa_pkg::OP_ALLOC) begin
      timer = timer - 16'd1;
      if (partial_hd < soa_pkg::NONE_MARK) begin
        s = partial_hd[5:0];
        r.slot = take_slot(s);
        r.slab = s;
        r.granted = 1'b1;
        if (stack_top[s] >= soa_pkg::EMPTY_MARK) begin
          unlink_slab(soa_pkg::TAG_PARTIAL, s);
          push_slab(soa_pkg::TAG_FULL, s);
        end
      end else begin
        if (spare_hd >= soa_pkg::NONE_MARK) grow_pool();
        if (spare_hd < soa_pkg::NONE_MARK) begin
          s = spare_hd[5:0];
          unlink_slab(soa_pkg::TAG_SPARE, s);
          used_slabs = used_slabs + 7'd1;
          if (used_slabs > peak_slabs) peak_slabs = used_slabs;
          push_slab(soa_pkg::TAG_PARTIAL, s);
          r.slot = take_slot(s);
          r.slab = s;
          r.granted = 1'b1;
        end
      end
      if (timer == 16'd0) r.reclaimed = run_maintenance(slab_limit);
    end else if (o == soa_pkg::OP_FREE) begin
      if ({1'b0, so} < slots_per_slab() && in_use(sl)) begin
        if (held_v) give_back(sl, so);
        else begin
          held_v = 1'b1;
          held_sl = sl;
          held_so = so;
        end
      end
    end else begin
      r.reclaimed = run_maintenance(o == soa_pkg::OP_MAINT ? slab_limit : 7'd0);
    end
    return r;
  endfunction

  function automatic void reset_model();
    objs_reg = 7'd64;
    interval_reg = 16'd1024;
    for (int i = 0; i < soa_pkg::NUM_SLABS*soa_pkg::MAX_SLOTS; i++) link[i] = '0;
    for (int s = 0; s < soa_pkg::NUM_SLABS; s++) begin
      stack_top[s] = soa_pkg::EMPTY_MARK;
      slab_fill[s] = '0;
      nxt[s] = soa_pkg::NONE_MARK;
      prv[s] = soa_pkg::NONE_MARK;
      tag[s] = soa_pkg::TAG_POOL;
    end
    partial_hd = soa_pkg::NONE_MARK;
    full_hd = soa_pkg::NONE_MARK;
    spare_hd = soa_pkg::NONE_MARK;
    used_slabs = '0;
    owned_slabs = '0;
    peak_slabs = '0;
    timer = interval_reg;
    slab_limit = 7'(soa_pkg::NUM_SLABS);
    held_v = 1'b0;
    held_sl = '0;
    held_so = '0;
    awaited.delete();
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      reset_model();
      errors = 0;
      grants = 0;
      reclaims = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == soa_pkg::CFG_OBJS) objs_reg = cfg_data[6:0];
        else begin
          interval_reg = cfg_data;
          timer = cfg_data;
        end
      end
      if (in_valid && !in_stall) awaited.push_back(predict_request(op, slab_index, slot_index));
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = awaited.pop_front();
          if (granted !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, granted);
            errors++;
          end
          if (out_slab !== want.slab) begin
            $error("out_slab: expected %0d, got %0d", want.slab, out_slab);
            errors++;
          end
          if (out_slot !== want.slot) begin
            $error("out_slot: expected %0d, got %0d", want.slot, out_slot);
            errors++;
          end
          if (reclaimed !== want.reclaimed) begin
            $error("reclaimed: expected %0d, got %0d", want.reclaimed, reclaimed);
            errors++;
          end
          grants += int'(want.granted);
          reclaims += int'(want.reclaimed);
        end
      end
    end
    pending = awaited.size();
  end

endmodule

>>> verif/testbench.sv
// Top level: clock, reset, request stimulus, configuration phases and verdict.
`timescale 1ns / 100ps
module testbench;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  op = soa_pkg::OP_ALLOC;
  logic [5:0]  slab_index = '0;
  logic [5:0]  slot_index = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        granted;
  logic [5:0]  out_slab;
  logic [5:0]  out_slot;
  logic        reclaimed;
  logic        cfg_we = 0;
  logic        cfg_index = soa_pkg::CFG_OBJS;
  logic [15:0] cfg_data = '0;
  int          errors, pending, grants, reclaims;
  logic        calm = 0;
  logic        hold_go = 0;
  logic        hold_done = 0;
  int          hold_cnt = 0;
  logic [11:0] live[$];
  int          sent = 0;

  always #5 clk = ~clk;

  slab_object_allocator DUT (.*);

  soa_checker checker_i (.*);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall && granted) live.push_back({out_slab, out_slot});
  end

  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt++;
      if (hold_cnt >= 400) hold_done <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 15);
    end
  end

  task automatic send(logic [1:0] o, logic [5:0] sl, logic [5:0] so);
    in_valid <= 1'b1;
    op <= o;
    slab_index <= sl;
    slot_index <= so;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic free_live();
    int k;
    logic [11:0] obj;
    if (live.size() == 0) begin
      send(soa_pkg::OP_FREE, 6'($urandom), 6'($urandom));
    end else begin
      k = $urandom_range(live.size() - 1);
      obj = live[k];
      live.delete(k);
      send(soa_pkg::OP_FREE, obj[11:6], obj[5:0]);
    end
  endtask

  task automatic random_requests(int count, int alloc_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < alloc_pct) send(soa_pkg::OP_ALLOC, 6'($urandom), 6'($urandom));
      else if (r < alloc_pct + 28) begin
        if ($urandom_range(9) == 0) send(soa_pkg::OP_FREE, 6'($urandom), 6'($urandom));
        else free_live();
      end else if (r < 92) send(soa_pkg::OP_MAINT, 6'($urandom), 6'($urandom));
      else send(soa_pkg::OP_MAINT_ZERO, 6'($urandom), 6'($urandom));
    end
  endtask

  initial begin
    #200_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(soa_pkg::OP_ALLOC, 6'd0, 6'd0);
    send(soa_pkg::OP_ALLOC, 6'h3F, 6'h3F);
    send(soa_pkg::OP_FREE, 6'd0, 6'd63);
    send(soa_pkg::OP_FREE, 6'd0, 6'd62);
    send(soa_pkg::OP_FREE, 6'd0, 6'd62);
    send(soa_pkg::OP_FREE, 6'h3F, 6'd0);
    send(soa_pkg::OP_FREE, 6'd0, 6'h3F);
    send(soa_pkg::OP_MAINT, 6'd0, 6'd0);
    send(soa_pkg::OP_MAINT_ZERO, 6'h3F, 6'h3F);
    send(soa_pkg::OP_MAINT, 6'd0, 6'd0);
    send(soa_pkg::OP_ALLOC, 6'd0, 6'd0);
    send(soa_pkg::OP_FREE, 6'd0, 6'd63);
    send(soa_pkg::OP_MAINT_ZERO, 6'd0, 6'd0);
    live.delete();
    write_reg(soa_pkg::CFG_OBJS, 16'hFFFF);
    write_reg(soa_pkg::CFG_INTERVAL, 16'd1);
    for (int i = 0; i < 6; i++) send(soa_pkg::OP_ALLOC, 6'd0, 6'd0);
    send(soa_pkg::OP_FREE, 6'h2A, 6'h15);
    send(soa_pkg::OP_MAINT, 6'd0, 6'd0);

    write_reg(soa_pkg::CFG_OBJS, 16'd2);
    write_reg(soa_pkg::CFG_INTERVAL, 16'd5);
    random_requests(300, 70);

    write_reg(soa_pkg::CFG_OBJS, 16'd0);
    write_reg(soa_pkg::CFG_INTERVAL, 16'hFFFF);
    random_requests(300, 60);

    write_reg(soa_pkg::CFG_OBJS, 16'd64);
    write_reg(soa_pkg::CFG_INTERVAL, 16'd0);
    hold_go <= 1'b1;
    random_requests(300, 50);

    write_reg(soa_pkg::CFG_OBJS, 16'd5);
    write_reg(soa_pkg::CFG_INTERVAL, 16'd7);
    calm <= 1'b1;
    random_requests(300, 55);
    calm <= 1'b0;

    write_reg(soa_pkg::CFG_OBJS, 16'd17);
    write_reg(soa_pkg::CFG_INTERVAL, 16'd3);
    random_requests(300, 55);

    write_reg(soa_pkg::CFG_OBJS, 16'd127);
    write_reg(soa_pkg::CFG_INTERVAL, 16'd40);
    random_requests(300, 50);

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d requests over seven register settings: %0d grants, %0d reclaims.",
             sent, grants, reclaims);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
hdl/soa_pkg.sv
hdl/soa_rec_mem.sv
hdl/slab_object_allocator.sv
verif/soa_checker.sv
verif/testbench.sv
